[hw/rtl/bed_pkg.sv]
`default_nettype none

package bed_pkg;

    // Default depth of the line stores, in pixels.
    localparam int DEFAULT_MAX_WIDTH = 2048;
    // Largest frame height that the row counter covers.
    localparam int MAX_HEIGHT = 4096;

    // Field widths of the result item and of the configuration registers.
    localparam int COL_W      = 11;
    localparam int ROW_W      = 12;
    localparam int IMG_W_W    = 12;
    localparam int IMG_H_W    = 13;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 13;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_DILATE_MODE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DIAMOND_SHAPE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT  = 2'd3;

    // Register values after reset.
    localparam logic [IMG_W_W-1:0] RESET_IMAGE_WIDTH  = 12'd640;
    localparam logic [IMG_H_W-1:0] RESET_IMAGE_HEIGHT = 13'd480;

    // Structuring elements over the 3x3 window, top row in the low bits.
    localparam logic [8:0] MASK_SQUARE  = 9'h1FF;
    localparam logic [8:0] MASK_DIAMOND = 9'h0BA;

    // Entries of the result queue.
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic                 dilate_mode;
        logic                 diamond_shape;
        logic [IMG_W_W-1:0]   image_width;
        logic [IMG_H_W-1:0]   image_height;
    } cfg_t;

    typedef struct packed {
        logic                 frame_last;
        logic                 out_white;
        logic [ROW_W-1:0]     out_row;
        logic [COL_W-1:0]     out_col;
    } result_t;

    // Results produced by one input pixel; second is used only with first.
    typedef struct packed {
        logic                 first_vld;
        logic                 second_vld;
        result_t              first;
        result_t              second;
    } push_t;

endpackage

`default_nettype wire

[hw/rtl/bed_line_buf.sv]
`default_nettype none

module bed_line_buf #(
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic                     wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic                          rd_data
);

    logic mem [DEPTH];
    logic rd_data_reg;

    // One row of pixels; written at one address and read at one address a cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hw/rtl/bed_core.sv]
`default_nettype none

module bed_core #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire bed_pkg::cfg_t                cfg,
    input  wire logic                         accept,
    input  wire logic                         pixel,
    input  wire logic                         upper_rd,
    input  wire logic                         lower_rd,
    output logic                              mem_wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]      mem_wr_addr,
    output logic [$clog2(MAX_WIDTH)-1:0]      mem_rd_addr,
    output logic                              upper_wr_data,
    output bed_pkg::push_t                    push
);

    import bed_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int CMP_W = (CW + 1 > 13) ? CW + 1 : 13;
    localparam logic [8:0] WINDOW_KEEP = 9'h0DB;

    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [8:0]       window_reg, window_next;

    logic [CMP_W-1:0]   w_ext, w_eff, w_last, col_ext, col_m1;
    logic [IMG_H_W-1:0] h_eff, h_m1;
    logic [ROW_W-1:0]   h_last, row_m1;
    logic               last_col, last_row, up, mid;
    logic               interior, border, white;
    logic [8:0]         mask, hit;
    result_t            int_res, bor_res;

    // Effective frame size, clamped to what the counters and stores cover.
    always_comb
    begin
        w_ext = CMP_W'(cfg.image_width);
        if (w_ext < CMP_W'(3))
            w_eff = CMP_W'(3);
        else if (w_ext > CMP_W'(MAX_WIDTH))
            w_eff = CMP_W'(MAX_WIDTH);
        else
            w_eff = w_ext;
        w_last = w_eff - CMP_W'(1);

        if (cfg.image_height < IMG_H_W'(3))
            h_eff = IMG_H_W'(3);
        else if (cfg.image_height > IMG_H_W'(MAX_HEIGHT))
            h_eff = IMG_H_W'(MAX_HEIGHT);
        else
            h_eff = cfg.image_height;
        h_m1   = h_eff - IMG_H_W'(1);
        h_last = h_m1[ROW_W-1:0];
    end

    // Position flags and the two pixels above the current one.
    assign col_ext  = CMP_W'(col_reg);
    assign col_m1   = col_ext - CMP_W'(1);
    assign row_m1   = row_reg - ROW_W'(1);
    assign last_col = (col_ext >= w_last);
    assign last_row = (row_reg >= h_last);
    assign up       = (row_reg >= ROW_W'(2)) & upper_rd;
    assign mid      = (row_reg >= ROW_W'(1)) & lower_rd;

    // Shift the window one column and bring in the new column.
    assign window_next = ((window_reg >> 1) & WINDOW_KEEP)
                       | {pixel, 2'b00, mid, 2'b00, up, 2'b00};

    // Erosion or dilation of the window under the selected element.
    always_comb
    begin
        mask  = cfg.diamond_shape ? MASK_DIAMOND : MASK_SQUARE;
        hit   = window_next & mask;
        white = cfg.dilate_mode ? (|hit) : (hit == mask);
    end

    assign interior = (col_ext >= CMP_W'(2)) && (row_reg >= ROW_W'(2))
                   && (col_ext <= w_last) && (row_reg <= h_last);
    assign border   = (col_reg == '0) || (row_reg == '0) || last_col || last_row;

    // Results of this pixel: the interior one first, then the border one.
    always_comb
    begin
        int_res.out_col    = col_m1[COL_W-1:0];
        int_res.out_row    = row_m1;
        int_res.out_white  = white;
        int_res.frame_last = 1'b0;

        bor_res.out_col    = col_ext[COL_W-1:0];
        bor_res.out_row    = row_reg;
        bor_res.out_white  = pixel;
        bor_res.frame_last = last_col && last_row;

        push.first_vld  = accept && (interior || border);
        push.second_vld = accept && interior && border;
        push.first      = interior ? int_res : bor_res;
        push.second     = bor_res;
    end

    // Raster position after this pixel.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            window_reg <= '0;
        end
        else if (accept)
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            window_reg <= window_next;
        end
    end

    // The stores are read one column ahead so the data is ready at the pixel.
    assign mem_wr_en     = accept;
    assign mem_wr_addr   = col_reg;
    assign mem_rd_addr   = accept ? col_next : col_reg;
    assign upper_wr_data = mid;

endmodule

`default_nettype wire

[hw/rtl/bed_out_queue.sv]
`default_nettype none

module bed_out_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bed_pkg::push_t    push,
    output logic                   room,
    output logic                   head_vld,
    output bed_pkg::result_t       head,
    input  wire logic              head_rdy
);

    import bed_pkg::*;

    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    result_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next, wr_ptr_second;
    logic [CNT_W-1:0] count_reg, count_next, n_push;
    logic             pop;

    // Bookkeeping for up to two writes and one read per cycle.
    assign n_push        = CNT_W'(push.first_vld) + CNT_W'(push.second_vld);
    assign pop           = head_vld && head_rdy;
    assign wr_ptr_second = wr_ptr_reg + PW'(1);
    assign wr_ptr_next   = wr_ptr_reg + PW'(n_push);
    assign rd_ptr_next   = rd_ptr_reg + PW'(pop);
    assign count_next    = count_reg + n_push - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (push.first_vld)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.second_vld)
        begin
            entry_reg[wr_ptr_second] <= push.second;
        end
    end

    // A new pixel is taken only while two results still fit.
    assign room     = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign head_vld = (count_reg != '0);
    assign head     = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

[hw/rtl/binary_erode_dilate_3x3.sv]
// 3x3 binary erosion and dilation on a raster pixel stream.
//
// Pixels enter on the s_ group, one bit in s_tdata[0], row by row from the top
// left. Results leave on the m_ group with their column and row, and m_tlast
// marks the result of the bottom-right pixel, the last one of a frame.
// A border pixel is sent on as it came; an interior pixel is sent when the
// pixel below and to the right of it arrives, ahead of that pixel's own
// border result, so the output is not in raster order.
// Throughput: one pixel per cycle while m_tready is high and each pixel yields
// at most one result. Last-column pixels from the third row on and last-row
// pixels from the third column on yield two, and the four-entry result queue
// then limits intake over that stretch.
// The two line stores are simple dual-port RAMs of MAX_WIDTH bits, read one
// column ahead so each pixel needs one read and one write in the same cycle.
// Reset clears the position counters, window and queue and loads the default
// registers (erosion, square element, 640 x 480). Configuration must be written
// by the user through cfg_we/cfg_addr/cfg_wdata only between frames; the block
// does not enforce this. When m_tready is low, results wait in the queue and
// s_tready drops once fewer than two slots are free.
`default_nettype none

module binary_erode_dilate_3x3 #(
    parameter int MAX_WIDTH = bed_pkg::DEFAULT_MAX_WIDTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Pixel input channel.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // [0] pixel_white
    // Result output channel.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [23:0]                          m_tdata,   // out_col, out_row, out_white
    output logic                                 m_tlast,   // frame_last
    // Configuration write port.
    input  wire logic                            cfg_we,
    input  wire logic [bed_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [bed_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import bed_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    cfg_t          cfg_reg;
    logic          accept, room;
    logic          upper_rd, lower_rd, upper_wr_data, mem_wr_en;
    logic [CW-1:0] mem_wr_addr, mem_rd_addr;
    push_t         push;
    result_t       head;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dilate_mode   <= 1'b0;
            cfg_reg.diamond_shape <= 1'b0;
            cfg_reg.image_width   <= RESET_IMAGE_WIDTH;
            cfg_reg.image_height  <= RESET_IMAGE_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_DILATE_MODE:   cfg_reg.dilate_mode   <= cfg_wdata[0];
                CFG_DIAMOND_SHAPE: cfg_reg.diamond_shape <= cfg_wdata[0];
                CFG_IMAGE_WIDTH:   cfg_reg.image_width   <= cfg_wdata[IMG_W_W-1:0];
                CFG_IMAGE_HEIGHT:  cfg_reg.image_height  <= cfg_wdata[IMG_H_W-1:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    assign s_tready = room;
    assign accept   = s_tvalid && s_tready;

    // Row above the current one.
    bed_line_buf #(
        .DEPTH   (MAX_WIDTH)
    ) u_lower_buf (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (s_tdata[0]),
        .rd_addr (mem_rd_addr),
        .rd_data (lower_rd)
    );

    // Row two above the current one.
    bed_line_buf #(
        .DEPTH   (MAX_WIDTH)
    ) u_upper_buf (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (upper_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (upper_rd)
    );

    // Window, position counters and the morphology decision.
    bed_core #(
        .MAX_WIDTH     (MAX_WIDTH)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .accept        (accept),
        .pixel         (s_tdata[0]),
        .upper_rd      (upper_rd),
        .lower_rd      (lower_rd),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_rd_addr   (mem_rd_addr),
        .upper_wr_data (upper_wr_data),
        .push          (push)
    );

    // Result queue between the window logic and the output channel.
    bed_out_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room     (room),
        .head_vld (m_tvalid),
        .head     (head),
        .head_rdy (m_tready)
    );

    assign m_tdata = {head.out_white, head.out_row, head.out_col};
    assign m_tlast = head.frame_last;

endmodule

`default_nettype wire

[hw/rtl/bed_checker.sv]
`default_nettype none

module bed_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tready,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,
    input  wire logic        m_tlast
);

    // A stalled result transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Input is held back only while results are pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with an empty result queue");

    // The bottom-right pixel of a frame is never in the first row or column.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (m_tdata[10:0] != 11'd0) && (m_tdata[22:11] != 12'd0))
        else $error("frame end marked at a first row or column");

    // No result is offered right after reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result offered out of reset");

endmodule

bind binary_erode_dilate_3x3 bed_checker u_bed_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
    import bed_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 200;

    typedef enum {PAT_CORNER, PAT_CENTER, PAT_RANDOM} pattern_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = 8'd0;    // [0] pixel_white
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;           // out_col, out_row, out_white
    logic                  m_tlast;           // frame_last
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Mirror of the block: registers, line stores, window and raster position.
    cfg_t                  shadow;
    bit                    line_upper [DEFAULT_MAX_WIDTH];
    bit                    line_lower [DEFAULT_MAX_WIDTH];
    logic [8:0]            nbhd;
    int                    col_pos;
    int                    row_pos;

    result_t               expected_pixels [$];
    result_t               rx_got;
    result_t               rx_want;
    int                    errors = 0;
    int                    pixels_sent = 0;
    int                    cycle_count = 0;
    bit                    gaps_on = 1'b1;
    bit                    hold_request = 1'b0;
    int                    hold_left = 0;
    int                    rx_gap = 0;

    binary_erode_dilate_3x3 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Out-of-range sizes are clamped to what the line stores and row counter cover.
    function automatic int eff_width();
        int w;
        w = int'(shadow.image_width);
        if (w < 3) w = 3;
        if (w > DEFAULT_MAX_WIDTH) w = DEFAULT_MAX_WIDTH;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = int'(shadow.image_height);
        if (h < 3) h = 3;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    // Work out the results that one accepted pixel causes, interior result first.
    task automatic predict_morphology(input bit pix);
        int         w;
        int         h;
        int         c;
        int         r;
        bit         up;
        bit         mid;
        bit         last_c;
        bit         last_r;
        bit         white;
        logic [8:0] mask;
        result_t    res;
        w = eff_width();
        h = eff_height();
        c = col_pos;
        r = row_pos;
        up = 1'b0;
        mid = 1'b0;
        if (r >= 2) up = line_upper[c];
        if (r >= 1) mid = line_lower[c];
        line_upper[c] = mid;
        line_lower[c] = pix;
        nbhd = ((nbhd >> 1) & 9'h0DB) | (9'(up) << 2) | (9'(mid) << 5) | (9'(pix) << 8);
        last_c = (c >= w - 1);
        last_r = (r >= h - 1);

        if (c >= 2 && r >= 2 && c <= w - 1 && r <= h - 1) begin
            mask = shadow.diamond_shape ? MASK_DIAMOND : MASK_SQUARE;
            if (shadow.dilate_mode)
                white = ((nbhd & mask) != 9'd0);
            else
                white = ((nbhd & mask) == mask);
            res.out_col = COL_W'(c - 1);
            res.out_row = ROW_W'(r - 1);
            res.out_white = white;
            res.frame_last = 1'b0;
            expected_pixels.push_back(res);
        end

        // Border pixels pass through as they came.
        if (c == 0 || r == 0 || last_c || last_r) begin
            res.out_col = COL_W'(c);
            res.out_row = ROW_W'(r);
            res.out_white = pix;
            res.frame_last = last_c && last_r;
            expected_pixels.push_back(res);
        end

        if (last_c) begin
            col_pos = 0;
            row_pos = last_r ? 0 : r + 1;
        end
        else begin
            col_pos = c + 1;
        end
    endtask

    // Offer one pixel, with an occasional gap ahead of it, and predict on acceptance.
    task automatic send_pixel(input bit pix);
        int gap;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, pix};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_morphology(pix);
        pixels_sent++;
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic wait_idle();
        int waited;
        s_tvalid <= 1'b0;
        waited = 0;
        while (expected_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (expected_pixels.size() != 0) begin
            $error("%0d expected results never arrived", expected_pixels.size());
            errors++;
            expected_pixels.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    // Write all four registers, one per cycle.
    task automatic program_regs(input bit mode, input bit diamond,
                                input logic [CFG_DATA_W-1:0] width,
                                input logic [CFG_DATA_W-1:0] height);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_DILATE_MODE;
        cfg_wdata <= CFG_DATA_W'(mode);
        @(posedge clk);
        cfg_addr <= CFG_DIAMOND_SHAPE;
        cfg_wdata <= CFG_DATA_W'(diamond);
        @(posedge clk);
        cfg_addr <= CFG_IMAGE_WIDTH;
        cfg_wdata <= width;
        @(posedge clk);
        cfg_addr <= CFG_IMAGE_HEIGHT;
        cfg_wdata <= height;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        shadow.dilate_mode = mode;
        shadow.diamond_shape = diamond;
        shadow.image_width = width[IMG_W_W-1:0];
        shadow.image_height = height;
    endtask

    // Directed patterns put one odd pixel on a background that the mode keeps.
    function automatic bit next_pixel(input pattern_t kind, input int density);
        bit bg;
        bg = !shadow.dilate_mode;
        case (kind)
            PAT_CORNER: return (col_pos == 0 && row_pos == 0) ? !bg : bg;
            PAT_CENTER: return (col_pos == 1 && row_pos == 1) ? !bg : bg;
            default:    return ($urandom_range(0, 99) < density);
        endcase
    endfunction

    // Send pixels until the raster position wraps to the start of a frame.
    task automatic finish_frame(input pattern_t kind, input int density);
        do
            send_pixel(next_pixel(kind, density));
        while (col_pos != 0 || row_pos != 0);
    endtask

    // Reset values, then a width and height cut in the middle of the first row.
    task automatic test_defaults_then_shrink();
        repeat (10) send_pixel(1'($urandom_range(0, 1)));
        wait_idle();
        program_regs(1'b0, 1'b0, 3, 3);
        finish_frame(PAT_RANDOM, 50);
        wait_idle();
    endtask

    // Each mode with each element on minimum frames with a lone odd pixel.
    task automatic test_element_shapes();
        for (int m = 0; m < 2; m++) begin
            for (int d = 0; d < 2; d++) begin
                program_regs(m[0], d[0], 3, 3);
                finish_frame(PAT_CORNER, 0);
                finish_frame(PAT_CENTER, 0);
                wait_idle();
            end
        end
    endtask

    // Sizes below the minimum and a width write with its unused top bit set.
    task automatic test_clamped_sizes();
        program_regs(1'b0, 1'b0, 0, 0);
        finish_frame(PAT_RANDOM, 80);
        wait_idle();
        program_regs(1'b1, 1'b1, 13'h1005, 2);
        finish_frame(PAT_RANDOM, 20);
        wait_idle();
        program_regs(1'b0, 1'b1, 1, 1);
        finish_frame(PAT_RANDOM, 50);
        wait_idle();
    endtask

    // A frame whose height is cut below the current row partway through it.
    task automatic test_height_cut();
        program_regs(1'b1, 1'b1, 4, 13'h1FFF);
        repeat (22) send_pixel(1'($urandom_range(0, 1)));
        wait_idle();
        program_regs(1'b0, 1'b1, 4, 3);
        finish_frame(PAT_RANDOM, 70);
        wait_idle();
    endtask

    // The receiver stalls long enough for the result queue to block intake.
    task automatic test_backpressure();
        program_regs(1'b1, 1'b0, 6, 4);
        hold_request = 1'b1;
        finish_frame(PAT_RANDOM, 40);
        wait_idle();
    endtask

    // Small frames with random settings and pixel density.
    task automatic test_random_frames(input int n_pixels);
        int stop_at;
        stop_at = pixels_sent + n_pixels;
        while (pixels_sent < stop_at) begin
            program_regs(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         CFG_DATA_W'($urandom_range(0, 8)),
                         CFG_DATA_W'($urandom_range(0, 6)));
            finish_frame(PAT_RANDOM, 20 + 30 * int'($urandom_range(0, 2)));
            wait_idle();
        end
    endtask

    // Result receiver: random stall bursts plus a requested long hold-off.
    always @(posedge clk)
    begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (rx_gap > 0) begin
            m_tready <= 1'b0;
            rx_gap--;
        end
        else if (gaps_on && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            rx_gap = $urandom_range(0, 3);
        end
        else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) begin
            rx_got = result_t'({m_tlast, m_tdata});
            if (expected_pixels.size() == 0) begin
                $error("unexpected result at col %0d row %0d", rx_got.out_col, rx_got.out_row);
                errors++;
            end
            else begin
                rx_want = expected_pixels.pop_front();
                if (rx_got !== rx_want) errors++;
                if (rx_got.out_col !== rx_want.out_col)
                    $error("out_col: expected %0d, actual %0d", rx_want.out_col, rx_got.out_col);
                if (rx_got.out_row !== rx_want.out_row)
                    $error("out_row: expected %0d, actual %0d", rx_want.out_row, rx_got.out_row);
                if (rx_got.out_white !== rx_want.out_white)
                    $error("out_white: expected %0d, actual %0d",
                           rx_want.out_white, rx_got.out_white);
                if (rx_got.frame_last !== rx_want.frame_last)
                    $error("frame_last: expected %0d, actual %0d",
                           rx_want.frame_last, rx_got.frame_last);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        shadow.dilate_mode = 1'b0;
        shadow.diamond_shape = 1'b0;
        shadow.image_width = RESET_IMAGE_WIDTH;
        shadow.image_height = RESET_IMAGE_HEIGHT;
        nbhd = 9'd0;
        col_pos = 0;
        row_pos = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults_then_shrink();
        test_element_shapes();
        test_clamped_sizes();
        test_height_cut();
        test_backpressure();
        test_random_frames(20);
        gaps_on = 1'b0;
        test_random_frames(20);

        wait_idle();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

[files.f]
hw/rtl/bed_pkg.sv
hw/rtl/bed_line_buf.sv
hw/rtl/bed_core.sv
hw/rtl/bed_out_queue.sv
hw/rtl/binary_erode_dilate_3x3.sv
hw/rtl/bed_checker.sv
verif/tb.sv
